// ===== sv/bzs_pkg.sv =====
// ----------------------------------------------------------------------------
// bzs_pkg: shared types and constants for the Bezier point splat block
// Fixed-point formats, register map and reset values, point type.
// ----------------------------------------------------------------------------
package bzs_pkg;

   // fixed-point formats
   localparam int T_FRAC_BITS     = 12;
   localparam int COORD_FRAC_BITS = 6;
   localparam int COORD_W         = 16;
   localparam int T_W             = T_FRAC_BITS + 1;
   localparam int INT_W           = COORD_W - COORD_FRAC_BITS;
   localparam int PIX_W           = INT_W + 1;
   localparam int WGT_W           = COORD_FRAC_BITS + 1;
   localparam int WPROD_W         = 2 * WGT_W;
   localparam int INTENSITY_W     = 8;
   localparam int INTENSITY_MAX   = 255;
   localparam int SHADE_W         = WPROD_W + INTENSITY_W + 1;

   // lerp datapath widths
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = DIFF_W + T_W + 1;

   localparam logic [T_W-1:0]         T_ONE      = T_W'(1) << T_FRAC_BITS;
   localparam logic [PROD_W-1:0]      T_HALF     = PROD_W'(1) << (T_FRAC_BITS - 1);
   localparam logic [WGT_W-1:0]       WGT_ONE    = WGT_W'(1) << COORD_FRAC_BITS;
   localparam logic [SHADE_W-1:0]     SHADE_HALF = SHADE_W'(1) << (2 * COORD_FRAC_BITS - 1);

   // register map
   localparam int REG_COUNT = 8;
   localparam int CSR_IDX_W = $clog2(REG_COUNT);

   localparam logic [CSR_IDX_W-1:0] REG_P0_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_P0_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_P1_X = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_P1_Y = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_P2_X = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_P2_Y = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_P3_X = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_P3_Y = CSR_IDX_W'(7);

   typedef logic [COORD_W-1:0] coord_type;

   localparam coord_type REG_RESET [REG_COUNT] = '{
      16'd640, 16'd640, 16'd44160, 16'd640,
      16'd640, 16'd44160, 16'd44160, 16'd44160
   };

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

endpackage

// ===== sv/bzs_lerp_cell.sv =====
// ----------------------------------------------------------------------------
// bzs_lerp_cell: one de Casteljau interpolation cell
// Registers round-half-up a + (b - a) * t on one coordinate.
// ----------------------------------------------------------------------------
module bzs_lerp_cell (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [bzs_pkg::T_W-1:0]     t,
   input  bzs_pkg::coord_type          a,
   input  bzs_pkg::coord_type          b,
   output bzs_pkg::coord_type          q
);

   logic signed [bzs_pkg::DIFF_W-1:0] diff;
   logic signed [bzs_pkg::PROD_W-1:0] prod;
   logic signed [bzs_pkg::PROD_W-1:0] rnd;
   logic signed [bzs_pkg::PROD_W-1:0] step;
   logic signed [bzs_pkg::PROD_W-1:0] sum;
   bzs_pkg::coord_type                q_ff;
   bzs_pkg::coord_type                q_in;

   // a*(1-t) + b*t == a*ONE + (b-a)*t, so the low part of a*ONE never rounds
   always_comb begin
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      prod = $signed(bzs_pkg::PROD_W'(diff)) *
             $signed(bzs_pkg::PROD_W'({1'b0, t}));
      rnd  = prod + $signed(bzs_pkg::T_HALF);
      step = rnd >>> bzs_pkg::T_FRAC_BITS;
      sum  = step + $signed(bzs_pkg::PROD_W'({1'b0, a}));
      q_in = sum[bzs_pkg::COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

// ===== sv/bzs_splat.sv =====
// ----------------------------------------------------------------------------
// bzs_splat: bilinear splat serializer
// Holds one curve point and emits its four weighted pixels in order.
// ----------------------------------------------------------------------------
module bzs_splat (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                p_valid,
   input  bzs_pkg::point_type                  p,
   output logic                                free,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bzs_pkg::PIX_W-1:0]           rsp_pixel_x,
   output logic [bzs_pkg::PIX_W-1:0]           rsp_pixel_y,
   output logic [bzs_pkg::INTENSITY_W-1:0]     rsp_intensity,
   output logic                                rsp_last
);

   logic                                 busy_ff, busy_in;
   logic [1:0]                           k_ff, k_in;
   logic [bzs_pkg::INT_W-1:0]            ix_ff, iy_ff;
   logic [bzs_pkg::COORD_FRAC_BITS-1:0]  fx_ff, fy_ff;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [bzs_pkg::PIX_W-1:0]            pixel_x_ff, pixel_y_ff;
   logic [bzs_pkg::INTENSITY_W-1:0]      intensity_ff;
   logic                                 last_ff;

   logic                                 take;
   logic                                 emit;
   logic                                 load;
   logic                                 dx, dy;
   logic [bzs_pkg::WGT_W-1:0]            wx, wy;
   logic [bzs_pkg::WPROD_W-1:0]          w;
   logic [bzs_pkg::SHADE_W-1:0]          shade_full;
   logic [bzs_pkg::SHADE_W-1:0]          shaded;
   logic [bzs_pkg::INTENSITY_W-1:0]      intensity;

   assign take = !rsp_valid_ff || !rsp_stall;
   assign emit = busy_ff && take;
   assign free = !busy_ff || (emit && (k_ff == 2'd3));
   assign load = p_valid && free;

   always_comb begin
      dx = k_ff[0];
      dy = k_ff[1];
      wx = dx ? bzs_pkg::WGT_W'(fx_ff) : bzs_pkg::WGT_ONE - bzs_pkg::WGT_W'(fx_ff);
      wy = dy ? bzs_pkg::WGT_W'(fy_ff) : bzs_pkg::WGT_ONE - bzs_pkg::WGT_W'(fy_ff);
      w  = bzs_pkg::WPROD_W'(wx) * bzs_pkg::WPROD_W'(wy);
      shade_full = bzs_pkg::SHADE_W'(w) * bzs_pkg::SHADE_W'(bzs_pkg::INTENSITY_MAX) +
                   bzs_pkg::SHADE_HALF;
      shaded = shade_full >> (2 * bzs_pkg::COORD_FRAC_BITS);
      if (shaded > bzs_pkg::SHADE_W'(bzs_pkg::INTENSITY_MAX)) begin
         intensity = bzs_pkg::INTENSITY_W'(bzs_pkg::INTENSITY_MAX);
      end else begin
         intensity = shaded[bzs_pkg::INTENSITY_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      if (emit) begin
         k_in = k_ff + 2'd1;
      end
      if (free) begin
         busy_in = p_valid;
      end
      if (load) begin
         k_in = 2'd0;
      end
      rsp_valid_in = take ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         k_ff         <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ix_ff <= p.x[bzs_pkg::COORD_W-1:bzs_pkg::COORD_FRAC_BITS];
         iy_ff <= p.y[bzs_pkg::COORD_W-1:bzs_pkg::COORD_FRAC_BITS];
         fx_ff <= p.x[bzs_pkg::COORD_FRAC_BITS-1:0];
         fy_ff <= p.y[bzs_pkg::COORD_FRAC_BITS-1:0];
      end
      if (emit) begin
         pixel_x_ff   <= bzs_pkg::PIX_W'(ix_ff) + bzs_pkg::PIX_W'(dx);
         pixel_y_ff   <= bzs_pkg::PIX_W'(iy_ff) + bzs_pkg::PIX_W'(dy);
         intensity_ff <= intensity;
         last_ff      <= (k_ff == 2'd3);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_x   = pixel_x_ff;
   assign rsp_pixel_y   = pixel_y_ff;
   assign rsp_intensity = intensity_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== sv/bezier_point_antialiased_splat.sv =====
// Flow: an accepted t passes row 1, row 2, row 3 and the splat point register,
//   then the first of four pixel transactions leaves the result register; the other
//   three follow one per cycle when rsp_stall stays low. The single result channel
//   sets the pace; the cell rows take one t a cycle while the splat can take a point.
// Reset: synchronous, active high; empties the pipeline and the result register
//   and loads the control points with their default curve.
// ----------------------------------------------------------------------------
// bezier_point_antialiased_splat: cubic Bezier point with bilinear splat
// Three rows of lerp cells (3, 2, 1 per coordinate) run de Casteljau on t;
// the resulting point is split into four weighted neighbor pixels.
// ----------------------------------------------------------------------------
module bezier_point_antialiased_splat (
   input  logic                                  clock,
   input  logic                                  reset,
   // input channel: one curve parameter per transaction
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [bzs_pkg::T_W-1:0]               req_t,
   // result channel: four pixel transactions per t
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bzs_pkg::PIX_W-1:0]             rsp_pixel_x,
   output logic [bzs_pkg::PIX_W-1:0]             rsp_pixel_y,
   output logic [bzs_pkg::INTENSITY_W-1:0]       rsp_intensity,
   output logic                                  rsp_last,
   // control point registers
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bzs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bzs_pkg::COORD_W-1:0]           csr_data
);

   // control point registers
   bzs_pkg::coord_type regs_ff [bzs_pkg::REG_COUNT];

   // stage valids, one per cell row
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic en1, en2, en3;
   logic splat_free;
   logic req_accept;

   // t travels beside the rows
   logic [bzs_pkg::T_W-1:0] t_sat;
   logic [bzs_pkg::T_W-1:0] t1_ff;
   logic [bzs_pkg::T_W-1:0] t2_ff;

   bzs_pkg::coord_type ctrl_x [4];
   bzs_pkg::coord_type ctrl_y [4];
   bzs_pkg::coord_type a_x [3];
   bzs_pkg::coord_type a_y [3];
   bzs_pkg::coord_type b_x [2];
   bzs_pkg::coord_type b_y [2];
   bzs_pkg::point_type pt;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= bzs_pkg::REG_RESET;
      end else if (csr_valid && csr_ready) begin
         regs_ff[csr_index] <= csr_data;
      end
   end

   assign ctrl_x[0] = regs_ff[bzs_pkg::REG_P0_X];
   assign ctrl_y[0] = regs_ff[bzs_pkg::REG_P0_Y];
   assign ctrl_x[1] = regs_ff[bzs_pkg::REG_P1_X];
   assign ctrl_y[1] = regs_ff[bzs_pkg::REG_P1_Y];
   assign ctrl_x[2] = regs_ff[bzs_pkg::REG_P2_X];
   assign ctrl_y[2] = regs_ff[bzs_pkg::REG_P2_Y];
   assign ctrl_x[3] = regs_ff[bzs_pkg::REG_P3_X];
   assign ctrl_y[3] = regs_ff[bzs_pkg::REG_P3_Y];

   // t above one saturates to one
   assign t_sat = (req_t > bzs_pkg::T_ONE) ? bzs_pkg::T_ONE : req_t;

   // each row advances when the next one is empty or moving on; bubbles collapse
   assign en3        = !v3_ff || splat_free;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_stall  = !en1;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      v1_in = en1 ? req_accept : v1_ff;
      v2_in = en2 ? v1_ff : v2_ff;
      v3_in = en3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         t1_ff <= t_sat;
      end
      if (en2) begin
         t2_ff <= t1_ff;
      end
   end

   // row 1: three cells per coordinate between neighboring control points
   for (genvar i = 0; i < 3; i++) begin : g_row1
      bzs_lerp_cell u_cell_x (
         .clock  (clock),
         .enable (en1),
         .t      (t_sat),
         .a      (ctrl_x[i]),
         .b      (ctrl_x[i+1]),
         .q      (a_x[i])
      );
      bzs_lerp_cell u_cell_y (
         .clock  (clock),
         .enable (en1),
         .t      (t_sat),
         .a      (ctrl_y[i]),
         .b      (ctrl_y[i+1]),
         .q      (a_y[i])
      );
   end

   // row 2: two cells per coordinate
   for (genvar i = 0; i < 2; i++) begin : g_row2
      bzs_lerp_cell u_cell_x (
         .clock  (clock),
         .enable (en2),
         .t      (t1_ff),
         .a      (a_x[i]),
         .b      (a_x[i+1]),
         .q      (b_x[i])
      );
      bzs_lerp_cell u_cell_y (
         .clock  (clock),
         .enable (en2),
         .t      (t1_ff),
         .a      (a_y[i]),
         .b      (a_y[i+1]),
         .q      (b_y[i])
      );
   end

   // row 3: the curve point
   bzs_lerp_cell u_row3_x (
      .clock  (clock),
      .enable (en3),
      .t      (t2_ff),
      .a      (b_x[0]),
      .b      (b_x[1]),
      .q      (pt.x)
   );

   bzs_lerp_cell u_row3_y (
      .clock  (clock),
      .enable (en3),
      .t      (t2_ff),
      .a      (b_y[0]),
      .b      (b_y[1]),
      .q      (pt.y)
   );

   // splat: floor/fraction split, weights, and the result register
   bzs_splat u_splat (
      .clock         (clock),
      .reset         (reset),
      .p_valid       (v3_ff),
      .p             (pt),
      .free          (splat_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_intensity (rsp_intensity),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== sv/bzs_checker.sv =====
// ----------------------------------------------------------------------------
// bzs_checker: port-level checks for the Bezier point splat block
// Watches reset behavior and the four-transaction result groups.
// ----------------------------------------------------------------------------
module bzs_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_stall,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [bzs_pkg::PIX_W-1:0]         rsp_pixel_x,
   input  logic [bzs_pkg::PIX_W-1:0]         rsp_pixel_y,
   input  logic [bzs_pkg::INTENSITY_W-1:0]   rsp_intensity,
   input  logic                              rsp_last
);

   // reset empties the result register
   a_reset_rsp_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // reset leaves the pipeline empty, so the input side is open
   a_reset_req_open: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

   // a group of four pixels goes out without gaps
   a_group_unbroken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("gap inside a pixel group");

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) &&
          $stable(rsp_intensity) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind bezier_point_antialiased_splat bzs_checker u_bzs_checker (.*);

// ===== bench/splat_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// splat_checker: pixel splat predictor and scoreboard
// Tracks control point writes, predicts the four weighted pixels of every
// accepted t and compares each pixel transaction against the oldest one owed.
// ----------------------------------------------------------------------------
module splat_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [bzs_pkg::T_W-1:0]            req_t,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [bzs_pkg::PIX_W-1:0]          rsp_pixel_x,
   input  logic [bzs_pkg::PIX_W-1:0]          rsp_pixel_y,
   input  logic [bzs_pkg::INTENSITY_W-1:0]    rsp_intensity,
   input  logic                               rsp_last,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [bzs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bzs_pkg::COORD_W-1:0]        csr_data,
   output int                                 failures,
   output int                                 pending,
   output int                                 checked
);
   import bzs_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0]       pixel_x;
      logic [PIX_W-1:0]       pixel_y;
      logic [INTENSITY_W-1:0] intensity;
      logic                   last;
   } splat_type;

   coord_type ctrl_pts [REG_COUNT];
   splat_type owed_pixels [$];
   int        fail_tally = 0;
   int        owed_count = 0;
   int        pixel_tally = 0;

   assign failures = fail_tally;
   assign pending  = owed_count;
   assign checked  = pixel_tally;

   // one de Casteljau step, rounded half up
   function automatic coord_type blend(coord_type a, coord_type b, logic [T_W-1:0] t);
      logic [31:0] acc;
      acc = 32'(a) * (32'(T_ONE) - 32'(t)) + 32'(b) * 32'(t)
            + (32'd1 << (T_FRAC_BITS - 1));
      return coord_type'(acc >> T_FRAC_BITS);
   endfunction

   function automatic coord_type curve_coord(coord_type c0, coord_type c1, coord_type c2,
                                             coord_type c3, logic [T_W-1:0] t);
      coord_type a0, a1, a2, b0, b1;
      a0 = blend(c0, c1, t);
      a1 = blend(c1, c2, t);
      a2 = blend(c2, c3, t);
      b0 = blend(a0, a1, t);
      b1 = blend(a1, a2, t);
      return blend(b0, b1, t);
   endfunction

   // queue the four neighbor pixels of the curve point at t
   function automatic void predict_splat(logic [T_W-1:0] t_in);
      logic [T_W-1:0]              t;
      coord_type                   px, py;
      logic [PIX_W-1:0]            ix, iy;
      logic [1:0][WGT_W-1:0]       wx, wy;
      logic [31:0]                 level;
      splat_type                   pix;
      t  = (t_in > T_ONE) ? T_ONE : t_in;
      px = curve_coord(ctrl_pts[REG_P0_X], ctrl_pts[REG_P1_X],
                       ctrl_pts[REG_P2_X], ctrl_pts[REG_P3_X], t);
      py = curve_coord(ctrl_pts[REG_P0_Y], ctrl_pts[REG_P1_Y],
                       ctrl_pts[REG_P2_Y], ctrl_pts[REG_P3_Y], t);
      ix = PIX_W'(px >> COORD_FRAC_BITS);
      iy = PIX_W'(py >> COORD_FRAC_BITS);
      wx[1] = WGT_W'(px[COORD_FRAC_BITS-1:0]);
      wx[0] = WGT_ONE - wx[1];
      wy[1] = WGT_W'(py[COORD_FRAC_BITS-1:0]);
      wy[0] = WGT_ONE - wy[1];
      for (int k = 0; k < 4; k++) begin
         level = (32'(wx[k[0]]) * 32'(wy[k[1]]) * 32'(INTENSITY_MAX) + 32'(SHADE_HALF))
                 >> (2 * COORD_FRAC_BITS);
         if (level > INTENSITY_MAX) begin
            level = INTENSITY_MAX;
         end
         pix.pixel_x   = ix + PIX_W'(k[0]);
         pix.pixel_y   = iy + PIX_W'(k[1]);
         pix.intensity = INTENSITY_W'(level);
         pix.last      = (k == 3);
         owed_pixels   = {owed_pixels, pix};
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_tally++;
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      splat_type want;
      if (reset) begin
         foreach (ctrl_pts[i]) ctrl_pts[i] = REG_RESET[i];
         owed_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            ctrl_pts[csr_index] = csr_data;
         end
         if (req_valid && !req_stall) begin
            predict_splat(req_t);
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_pixels.size() == 0) begin
               $error("unexpected pixel transaction (%0d,%0d)", rsp_pixel_x, rsp_pixel_y);
               fail_tally++;
            end else begin
               want = owed_pixels.pop_front();
               pixel_tally++;
               check_field("pixel_x", want.pixel_x, rsp_pixel_x);
               check_field("pixel_y", want.pixel_y, rsp_pixel_y);
               check_field("intensity", want.intensity, rsp_intensity);
               check_field("last", want.last, rsp_last);
            end
         end
      end
      owed_count = owed_pixels.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: Bezier point splat block level test
// Drives curve parameters and control point writes with bursty traffic and
// random back-pressure; splat_checker predicts and scores every pixel.
// ----------------------------------------------------------------------------
module testbench;
   import bzs_pkg::*;

   localparam int PERIOD       = 10;
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off, fills the pipe
   localparam int DRAIN_CYCLES = 12;     // settle margin after the last owed pixel returns
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_CURVES = 6;
   localparam int ITEMS_PER_CURVE = 68;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD} stall_mode_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [T_W-1:0]          req_t = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [PIX_W-1:0]        rsp_pixel_x;
   logic [PIX_W-1:0]        rsp_pixel_y;
   logic [INTENSITY_W-1:0]  rsp_intensity;
   logic                    rsp_last;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [COORD_W-1:0]      csr_data = '0;

   int failures;
   int pending;
   int checked;

   // flood: sender drops its gaps and the receiver takes its long hold-off
   bit                flood = 1'b0;
   int                cycle_count = 0;
   int                items_sent = 0;
   int                curves_loaded = 0;
   logic [T_W-1:0]    t_list [$];
   coord_type         curve_regs [REG_COUNT];

   always #(PERIOD / 2) clock = ~clock;

   bezier_point_antialiased_splat DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_t         (req_t),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_intensity (rsp_intensity),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   splat_checker check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_t         (req_t),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_intensity (rsp_intensity),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .failures      (failures),
      .pending       (pending),
      .checked       (checked)
   );

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d pixels still owed", cycle_count, pending);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // t mix: mostly in range, some saturating above one, ends hit often
   function automatic logic [T_W-1:0] pick_t();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return T_ONE;
         2:       return '1;
         3, 4:    return T_W'($urandom_range(T_ONE + 1, (1 << T_W) - 1));
         default: return T_W'($urandom_range(0, T_ONE));
      endcase
   endfunction

   // control point mix: edges of the Q10.6 range now and then
   function automatic coord_type pick_coord();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return coord_type'($urandom_range(0, (1 << COORD_W) - 1));
      endcase
   endfunction

   // wait at negedges (race free) until every owed pixel came back, then a
   // little longer; returns on a rising edge, ready to drive
   task automatic settle();
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      @(posedge clock);
   endtask

   // write all eight control point registers from curve_regs while idle
   task automatic apply_curve();
      settle();
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data  <= curve_regs[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      curves_loaded++;
   endtask

   // send count t transactions in bursts; directed ones come from t_list.
   // Valid stays up across a burst, so only one assignment per edge.
   task automatic play(input int count, input bit directed);
      int burst;
      burst = $urandom_range(1, 8);
      for (int n = 0; n < count; n++) begin
         req_valid <= 1'b1;
         req_t     <= directed ? t_list[n] : pick_t();
         do @(posedge clock); while (req_stall);
         items_sent++;
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 8);
            // some bursts run straight into the next one
            if (!flood && $urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;
   endtask

   // receiver: stall pattern changes after random spans; the first time
   // flood is seen it holds off for HOLD_CYCLES so the block backs up
   initial begin : rsp_pacer
      stall_mode_type mode;
      int             span;
      int             tick;
      bit             held;
      held = 1'b0;
      tick = 0;
      forever begin
         mode = stall_mode_type'($urandom_range(STALL_NONE, STALL_EVERY_THIRD));
         span = $urandom_range(16, 96);
         repeat (span) begin
            @(posedge clock);
            tick++;
            if (flood && !held) begin
               held = 1'b1;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
            end else begin
               case (mode)
                  STALL_NONE:  rsp_stall <= 1'b0;
                  STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                  STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default:     rsp_stall <= (tick % 3 == 0);
               endcase
            end
         end
      end
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // default curve after reset: t at both ends (integer corner, so three
      // zero-weight pixels), midpoints, saturation above one, all t bits set
      t_list = '{T_W'(0), T_W'(1), T_W'(1024), T_W'(2047), T_W'(2048), T_W'(2049),
                 T_W'(3072), T_W'(4095), T_ONE, T_ONE + T_W'(1), T_W'(6000),
                 T_W'(4096 + 2048), '1};
      play(t_list.size(), 1'b1);

      // all control points at the origin: every point lands on 0,0, so only pixel 0,0 gets weight
      foreach (curve_regs[i]) curve_regs[i] = '0;
      apply_curve();
      t_list = '{T_W'(0), T_W'(2048), T_ONE, '1};
      play(t_list.size(), 1'b1);

      // all at the top of the range: ix+1 reaches 1024, fraction 63
      foreach (curve_regs[i]) curve_regs[i] = '1;
      apply_curve();
      t_list = '{T_W'(0), T_W'(2048), T_ONE, '1};
      play(t_list.size(), 1'b1);

      // zigzag between opposite corners
      curve_regs[REG_P0_X] = '0;
      curve_regs[REG_P0_Y] = '1;
      curve_regs[REG_P1_X] = '1;
      curve_regs[REG_P1_Y] = '0;
      curve_regs[REG_P2_X] = '0;
      curve_regs[REG_P2_Y] = '1;
      curve_regs[REG_P3_X] = '1;
      curve_regs[REG_P3_Y] = '0;
      apply_curve();
      t_list = '{T_W'(1000), T_W'(2048), T_W'(3000)};
      play(t_list.size(), 1'b1);

      // random curves with random t; one of them runs flooded
      for (int c = 0; c < RANDOM_CURVES; c++) begin
         foreach (curve_regs[i]) curve_regs[i] = pick_coord();
         apply_curve();
         if (c == 2) begin
            flood <= 1'b1;
         end
         play(ITEMS_PER_CURVE, 1'b0);
         flood <= 1'b0;
      end

      settle();
      $display("Sent %0d curve parameters over %0d control point loads plus reset defaults,",
               items_sent, curves_loaded);
      $display("scored %0d pixel transactions under bursty traffic and back-pressure.",
               checked);
      if (failures == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/bzs_pkg.sv
sv/bzs_lerp_cell.sv
sv/bzs_splat.sv
sv/bezier_point_antialiased_splat.sv
sv/bzs_checker.sv
bench/splat_checker.sv
bench/testbench.sv
